// ===== rtl/core/american_binomial_pricer_defines.svh =====
// Assertion macros shared by the pricer RTL.
`ifndef AMERICAN_BINOMIAL_PRICER_DEFINES_SVH
`define AMERICAN_BINOMIAL_PRICER_DEFINES_SVH

// Plain property, checked on every clock outside reset.
`define ABP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Trigger in one cycle, consequence in the next.
`define ABP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/abp_pkg.sv =====
// Types and constants of the binomial option pricer.
package abp_pkg;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 32;

	// configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_TREE_DEPTH      = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_UP_FACTOR       = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_UP_RATIO_SQ     = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_NODE_FACTOR = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_UP_PROB         = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_DISCOUNT   = 3'd5;

	// register reset values, Q2.30 where a factor
	localparam logic [9:0]  RST_TREE_DEPTH      = 10'd1;
	localparam logic [31:0] RST_UP_FACTOR       = 32'h4000_0000;
	localparam logic [31:0] RST_UP_RATIO_SQ     = 32'h4000_0000;
	localparam logic [30:0] RST_LOW_NODE_FACTOR = 31'h4000_0000;
	localparam logic [30:0] RST_UP_PROB         = 31'h2000_0000;
	localparam logic [30:0] RST_STEP_DISCOUNT   = 31'h4000_0000;

	typedef struct packed {
		logic [31:0] spot_price;
		logic [31:0] strike_price;
		logic        is_put;
	} abp_in_t;

	typedef struct packed {
		logic [31:0] option_value;
		logic        saturated;
	} abp_out_t;

	typedef struct packed {
		logic [9:0]  tree_depth;
		logic [31:0] up_factor;
		logic [31:0] up_ratio_sq;
		logic [30:0] low_node_factor;
		logic [30:0] up_prob;
		logic [30:0] step_discount;
	} abp_cfg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOW_MUL,
		S_LOW_RES,
		S_TERM_WR,
		S_TERM_RES,
		S_ROW_MUL,
		S_ROW_RES,
		S_N_PMUL,
		S_N_QMUL,
		S_N_ADD,
		S_N_DMUL,
		S_N_WR,
		S_N_PRICE,
		S_DONE
	} abp_state_t;

endpackage

// ===== rtl/core/abp_mul.sv =====
// Shared fixed-point multiplier: registered product, truncating shift, saturation.
module abp_mul #(
	parameter int PRICE_BITS       = 32,
	parameter int FACTOR_BITS      = 32,
	parameter int FACTOR_FRAC_BITS = 30
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [PRICE_BITS-1:0]  a,
	input  logic [FACTOR_BITS-1:0] b,
	output logic [PRICE_BITS-1:0]  res,
	output logic                   sat
);
	localparam int PW = PRICE_BITS + FACTOR_BITS;

	logic [PW-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= {{FACTOR_BITS{1'b0}}, a} * {{PRICE_BITS{1'b0}}, b};
		end
	end

	// bits above the price range after the shift mean overflow
	assign sat = |prod_q[PW-1:FACTOR_FRAC_BITS+PRICE_BITS];
	assign res = sat ? {PRICE_BITS{1'b1}}
		: prod_q[FACTOR_FRAC_BITS+PRICE_BITS-1:FACTOR_FRAC_BITS];

endmodule

// ===== rtl/core/abp_node_mem.sv =====
// Node value store: one write port, one registered read port.
module abp_node_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/abp_ctrl.sv =====
// Sequencer and datapath for backward induction over the node store.
`include "american_binomial_pricer_defines.svh"

module abp_ctrl #(
	parameter int MAX_STEPS        = 1023,
	parameter int PRICE_BITS       = 32,
	parameter int FACTOR_FRAC_BITS = 30
) (
	input  logic               clk,
	input  logic               arst_n,
	input  abp_pkg::abp_cfg_t  cfg,
	input  logic               in_valid,
	output logic               in_stall,
	input  abp_pkg::abp_in_t   in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output abp_pkg::abp_out_t  out_data
);
	import abp_pkg::*;

	localparam int AW = $clog2(MAX_STEPS + 1);
	localparam int FW = (FACTOR_FRAC_BITS + 1 > 32) ? FACTOR_FRAC_BITS + 1 : 32;
	localparam int EW = (PRICE_BITS > 32) ? PRICE_BITS : 32;
	localparam int DW = (AW > 10) ? AW : 10;

	localparam logic [FW-1:0] FACTOR_ONE = {{(FW-1){1'b0}}, 1'b1} << FACTOR_FRAC_BITS;
	localparam logic [EW-1:0] PMAX_W     = EW'({PRICE_BITS{1'b1}});
	localparam logic [EW-1:0] OUT_MAX_W  = EW'(32'hFFFF_FFFF);
	localparam logic [DW-1:0] MAXS_W     = DW'(MAX_STEPS);

	function automatic logic [PRICE_BITS-1:0] payoff(
		input logic [PRICE_BITS-1:0] price,
		input logic [PRICE_BITS-1:0] strike,
		input logic                  put
	);
		logic [PRICE_BITS-1:0] r;
		r = '0;
		if (put) begin
			if (strike > price) r = strike - price;
		end else begin
			if (price > strike) r = price - strike;
		end
		return r;
	endfunction

	abp_state_t state_q, state_d;

	logic [PRICE_BITS-1:0] spot_q, strike_q, start_q, price_q, vlo_q, pa_q, sum_q, ex_q, last_q;
	logic                  put_q, sat_q;
	logic [AW-1:0]         n_q, i_q, step_q;
	logic [FW-1:0]         p_q, q_q;
	logic                  out_valid_q;
	abp_out_t              out_data_q;

	logic                  mul_en;
	logic [PRICE_BITS-1:0] mul_a, mul_res;
	logic [FW-1:0]         mul_b;
	logic                  mul_sat;

	logic                  mem_we, mem_re;
	logic [AW-1:0]         mem_waddr, mem_raddr;
	logic [PRICE_BITS-1:0] mem_wdata, mem_rdata;

	// input clamps, depth clamp, probability clamp
	logic [EW-1:0]         spot_w, strike_w, root_w;
	logic                  spot_sat, strike_sat, root_sat;
	logic [DW-1:0]         depth_w;
	logic [FW-1:0]         prob_w, prob_c;

	logic [PRICE_BITS-1:0] pay_now, node_new, sum_val;
	logic [PRICE_BITS:0]   sum_full;
	logic                  load_out;

	assign spot_w     = EW'(in_data.spot_price);
	assign strike_w   = EW'(in_data.strike_price);
	assign spot_sat   = spot_w > PMAX_W;
	assign strike_sat = strike_w > PMAX_W;
	assign depth_w    = DW'(cfg.tree_depth);
	assign prob_w     = FW'(cfg.up_prob);
	assign prob_c     = (prob_w > FACTOR_ONE) ? FACTOR_ONE : prob_w;

	assign pay_now  = payoff(price_q, strike_q, put_q);
	assign node_new = (mul_res > ex_q) ? mul_res : ex_q;
	assign sum_full = {1'b0, pa_q} + {1'b0, mul_res};
	assign sum_val  = sum_full[PRICE_BITS] ? {PRICE_BITS{1'b1}} : sum_full[PRICE_BITS-1:0];

	assign root_w   = EW'(last_q);
	assign root_sat = root_w > OUT_MAX_W;
	assign load_out = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	abp_mul #(
		.PRICE_BITS       (PRICE_BITS),
		.FACTOR_BITS      (FW),
		.FACTOR_FRAC_BITS (FACTOR_FRAC_BITS)
	) u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.res (mul_res),
		.sat (mul_sat)
	);

	abp_node_mem #(
		.DEPTH (MAX_STEPS + 1),
		.AW    (AW),
		.WIDTH (PRICE_BITS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:     if (in_valid) state_d = S_LOW_MUL;
			S_LOW_MUL:  state_d = S_LOW_RES;
			S_LOW_RES:  state_d = S_TERM_WR;
			S_TERM_WR: begin
				if (i_q != n_q) state_d = S_TERM_RES;
				else if (n_q == '0) state_d = S_DONE;
				else state_d = S_ROW_MUL;
			end
			S_TERM_RES: state_d = S_TERM_WR;
			S_ROW_MUL:  state_d = S_ROW_RES;
			S_ROW_RES:  state_d = S_N_PMUL;
			S_N_PMUL:   state_d = S_N_QMUL;
			S_N_QMUL:   state_d = S_N_ADD;
			S_N_ADD:    state_d = S_N_DMUL;
			S_N_DMUL:   state_d = S_N_WR;
			S_N_WR: begin
				if (i_q != step_q) state_d = S_N_PRICE;
				else if (step_q == '0) state_d = S_DONE;
				else state_d = S_ROW_MUL;
			end
			S_N_PRICE:  state_d = S_N_PMUL;
			S_DONE:     if (load_out) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// multiplier and memory controls
	always_comb begin
		mul_en    = 1'b0;
		mul_a     = price_q;
		mul_b     = FW'(cfg.up_ratio_sq);
		mem_we    = 1'b0;
		mem_waddr = i_q;
		mem_wdata = pay_now;
		mem_re    = 1'b0;
		mem_raddr = '0;
		case (state_q)
			S_LOW_MUL: begin
				mul_en = 1'b1;
				mul_a  = spot_q;
				mul_b  = FW'(cfg.low_node_factor);
			end
			S_TERM_WR: begin
				mem_we = 1'b1;
				mul_en = (i_q != n_q);
			end
			S_ROW_MUL: begin
				mul_en = 1'b1;
				mul_a  = start_q;
				mul_b  = FW'(cfg.up_factor);
				mem_re = 1'b1;
			end
			S_ROW_RES: begin
				mem_re    = 1'b1;
				mem_raddr = AW'(1);
			end
			S_N_PMUL: begin
				mul_en = 1'b1;
				mul_a  = mem_rdata;
				mul_b  = p_q;
			end
			S_N_QMUL: begin
				mul_en = 1'b1;
				mul_a  = vlo_q;
				mul_b  = q_q;
			end
			S_N_DMUL: begin
				mul_en = 1'b1;
				mul_a  = sum_q;
				mul_b  = FW'(cfg.step_discount);
			end
			S_N_WR: begin
				mem_we    = 1'b1;
				mem_wdata = node_new;
				mul_en    = (i_q != step_q);
				mem_re    = (i_q != step_q);
				mem_raddr = i_q + AW'(2);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					spot_q   <= spot_sat ? PRICE_BITS'(PMAX_W) : PRICE_BITS'(spot_w);
					strike_q <= strike_sat ? PRICE_BITS'(PMAX_W) : PRICE_BITS'(strike_w);
					put_q    <= in_data.is_put;
					sat_q    <= spot_sat | strike_sat;
					n_q      <= (depth_w > MAXS_W) ? AW'(MAXS_W) : AW'(depth_w);
					p_q      <= prob_c;
					q_q      <= FACTOR_ONE - prob_c;
					i_q      <= '0;
				end
			end
			S_LOW_RES: begin
				start_q <= mul_res;
				price_q <= mul_res;
				sat_q   <= sat_q | mul_sat;
			end
			S_TERM_WR: begin
				last_q <= pay_now;
				step_q <= n_q - AW'(1);
			end
			S_TERM_RES: begin
				price_q <= mul_res;
				sat_q   <= sat_q | mul_sat;
				i_q     <= i_q + AW'(1);
			end
			S_ROW_RES: begin
				start_q <= mul_res;
				price_q <= mul_res;
				sat_q   <= sat_q | mul_sat;
				i_q     <= '0;
				vlo_q   <= mem_rdata;
			end
			S_N_PMUL: ex_q <= pay_now;
			S_N_QMUL: begin
				pa_q  <= mul_res;
				sat_q <= sat_q | mul_sat;
			end
			S_N_ADD: begin
				sum_q <= sum_val;
				sat_q <= sat_q | mul_sat | sum_full[PRICE_BITS];
			end
			S_N_WR: begin
				last_q <= node_new;
				sat_q  <= sat_q | mul_sat;
				vlo_q  <= mem_rdata;
				if (i_q == step_q) step_q <= step_q - AW'(1);
			end
			S_N_PRICE: begin
				price_q <= mul_res;
				sat_q   <= sat_q | mul_sat;
				i_q     <= i_q + AW'(1);
			end
			S_DONE: begin
				if (load_out) begin
					out_data_q.option_value <= root_sat ? 32'hFFFF_FFFF : 32'(root_w);
					out_data_q.saturated    <= sat_q | root_sat;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`ABP_ASSERT(a_no_rw_clash, mem_we && mem_re |-> mem_waddr != mem_raddr, "node read and write collide")
	`ABP_ASSERT(a_wr_in_tree, mem_we |-> mem_waddr <= n_q, "node write beyond tree depth")
	`ABP_ASSERT(a_node_in_row, state_q == S_N_WR |-> i_q <= step_q, "node index past row end")
	`ABP_ASSERT_NEXT(a_result_load, load_out, out_valid_q && state_q == S_IDLE, "result not presented")

endmodule

// ===== rtl/core/american_binomial_pricer.sv =====
// Top level of the American option pricer: configuration registers and core.
//
// Prices one American option per transaction by Cox-Ross-Rubinstein backward
// induction over a tree of N = tree_depth steps (clamped to MAX_STEPS). Prices
// are unsigned Q16.16, factors Q2.30; every product truncates, and any overflow
// saturates and sets the saturated flag of the result. One shared multiplier
// with a registered product does all the work: the terminal row is written
// node by node, then each earlier row starts with a price step and each node
// takes the up and down products, their sum, the discount and the exercise
// compare. The input is stalled while an option is priced; a finished result
// waits in the output register while the next transaction is accepted. The
// user writes configuration only while the block is idle; the block does not
// enforce this. Node storage needs no clearing after reset.
module american_binomial_pricer #(
	parameter int MAX_STEPS        = 1023,
	parameter int PRICE_BITS       = 32,
	parameter int FACTOR_FRAC_BITS = 30
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [abp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [abp_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  abp_pkg::abp_in_t                     in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output abp_pkg::abp_out_t                    out_data
);
	import abp_pkg::*;

	abp_cfg_t cfg_q;

	// register file; unknown indexes drop the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tree_depth      <= RST_TREE_DEPTH;
			cfg_q.up_factor       <= RST_UP_FACTOR;
			cfg_q.up_ratio_sq     <= RST_UP_RATIO_SQ;
			cfg_q.low_node_factor <= RST_LOW_NODE_FACTOR;
			cfg_q.up_prob         <= RST_UP_PROB;
			cfg_q.step_discount   <= RST_STEP_DISCOUNT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TREE_DEPTH:      cfg_q.tree_depth      <= cfg_wdata[9:0];
				REG_UP_FACTOR:       cfg_q.up_factor       <= cfg_wdata;
				REG_UP_RATIO_SQ:     cfg_q.up_ratio_sq     <= cfg_wdata;
				REG_LOW_NODE_FACTOR: cfg_q.low_node_factor <= cfg_wdata[30:0];
				REG_UP_PROB:         cfg_q.up_prob         <= cfg_wdata[30:0];
				REG_STEP_DISCOUNT:   cfg_q.step_discount   <= cfg_wdata[30:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer, shared multiplier and node store
	abp_ctrl #(
		.MAX_STEPS        (MAX_STEPS),
		.PRICE_BITS       (PRICE_BITS),
		.FACTOR_FRAC_BITS (FACTOR_FRAC_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
